// ===== hdl/accel_tilt_angles_core_defines.svh =====
//------------------------------------------------------------------------------
// accel_tilt_angles_core_defines
// assertion macros shared by the tilt angle datapath
//------------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLES_CORE_DEFINES_SVH

// same-cycle implication
`define ATA_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("ata assertion failed");

// next-cycle implication
`define ATA_ASSERT_NXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("ata assertion failed");

`endif

// ===== hdl/ata_pkg.sv =====
//------------------------------------------------------------------------------
// ata_pkg
// types, widths and the sin squared threshold table for the tilt angle core
//------------------------------------------------------------------------------
package ata_pkg;

    localparam int IN_W         = 16;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 31;
    localparam int T_W          = 32;
    localparam int CNT_W        = 7;
    localparam int ANG_W        = 8;
    localparam int TAB_W        = 64;
    localparam int TAB_DEPTH    = 128;
    localparam int HALF_W       = 32;
    localparam int PROD_W       = 64;
    localparam int FRAC_W       = 62;
    localparam int CMP_W        = 96;
    localparam int SEARCH_STEPS = 7;

    localparam logic [TAB_W-1:0] Q_ONE    = 64'h4000_0000_0000_0000;
    localparam logic [TAB_W-1:0] PI_Q62   = 64'hC90F_DAA2_2168_C234;
    localparam logic [TAB_W-1:0] RAD1_Q62 = PI_Q62 / 64'd180;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll_degrees;
        logic signed [ANG_W-1:0] pitch_degrees;
    } angles_t;

    typedef logic [TAB_DEPTH-1:0][TAB_W-1:0] sin2_tab_t;

    typedef struct packed {
        logic [SQ_W-1:0] x2;
        logic [SQ_W-1:0] y2;
        logic [SQ_W-1:0] z2;
        logic            x_neg;
        logic            y_neg;
    } sq_t;

    typedef struct packed {
        logic [SQ_W-1:0]  n2;
        logic [CNT_W-1:0] cnt;
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           zero;
        lane_t          roll;
        lane_t          pitch;
    } srch_t;

    typedef struct packed {
        srch_t            s;
        logic [TAB_W-1:0] roll_tab;
        logic [TAB_W-1:0] pitch_tab;
    } lk_t;

    typedef struct packed {
        logic [PROD_W-1:0] hi;
        logic [PROD_W-1:0] lo;
    } prod_t;

    typedef struct packed {
        srch_t s;
        prod_t roll_prod;
        prod_t pitch_prod;
    } mul_t;

    // q2.62 product, truncated
    function automatic logic [TAB_W-1:0] mulq(input logic [TAB_W-1:0] a,
                                              input logic [TAB_W-1:0] b);
        logic [2*TAB_W-1:0] p;
        p = (2*TAB_W)'(a) * (2*TAB_W)'(b);
        return p[TAB_W+FRAC_W-1:FRAC_W];
    endfunction

    // sin^2 of whole degrees in q2.62, entry 90 is one, entries above never pass
    function automatic sin2_tab_t build_sin2_tab();
        sin2_tab_t        tab;
        logic [TAB_W-1:0] x;
        logic [TAB_W-1:0] x2;
        logic [TAB_W-1:0] x3;
        logic [TAB_W-1:0] x4;
        logic [TAB_W-1:0] x5;
        logic [TAB_W-1:0] x6;
        logic [TAB_W-1:0] x7;
        logic [TAB_W-1:0] x8;
        logic [TAB_W-1:0] s1;
        logic [TAB_W-1:0] c1;
        logic [TAB_W-1:0] s;
        logic [TAB_W-1:0] c;
        logic [TAB_W-1:0] ns;
        logic [TAB_W-1:0] nc;
        x  = RAD1_Q62;
        x2 = mulq(x, x);
        x3 = mulq(x2, x);
        x4 = mulq(x2, x2);
        x5 = mulq(x3, x2);
        x6 = mulq(x4, x2);
        x7 = mulq(x5, x2);
        x8 = mulq(x4, x4);
        s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
        c1 = Q_ONE - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
        tab = '0;
        s = s1;
        c = c1;
        for (int k = 1; k < 90; k++)
        begin
            tab[k] = mulq(s, s);
            nc = mulq(c, c1) - mulq(s, s1);
            ns = mulq(s, c1) + mulq(c, s1);
            c = nc;
            s = ns;
        end
        // thirty, forty-five and sixty degrees are exact ratios
        tab[30] = Q_ONE >> 2;
        tab[45] = Q_ONE >> 1;
        tab[60] = (Q_ONE >> 2) * 64'd3;
        tab[90] = Q_ONE;
        for (int k = 91; k < TAB_DEPTH; k++)
        begin
            tab[k] = Q_ONE << 1;
        end
        return tab;
    endfunction

    localparam sin2_tab_t SIN2_TAB = build_sin2_tab();

    function automatic logic [MAG_W-1:0] abs16(input logic signed [IN_W-1:0] v);
        return v[IN_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // n^2 * 2^62 >= sin^2 * t
    function automatic logic thr_pass(input logic [SQ_W-1:0] n2, input prod_t p);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        lhs = CMP_W'(n2) << FRAC_W;
        rhs = (CMP_W'(p.hi) << HALF_W) + CMP_W'(p.lo);
        return lhs >= rhs;
    endfunction

endpackage

// ===== hdl/accel_tilt_angles_core.sv =====
//------------------------------------------------------------------------------
// accel_tilt_angles_core
// throughput: one sample per cycle unless angles_stall holds the output; squares,
//   sum, then 7 search steps of table read, 64x32 product as two 32x32 partial
//   products, and 96-bit compare
// each stage advances when the one after it is empty or advancing
// reset: asynchronous, clears all valid bits; no clearing pass is needed
//------------------------------------------------------------------------------
`include "accel_tilt_angles_core_defines.svh"

module accel_tilt_angles_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ata_pkg::sample_t  sample,
    output logic              angles_valid,
    input  logic              angles_stall,
    output ata_pkg::angles_t  angles
);
    import ata_pkg::*;

    logic             sq_valid_reg;
    logic             sq_rdy;
    sq_t              sq_reg;
    sq_t              sq_next;
    logic [MAG_W-1:0] x_mag;
    logic [MAG_W-1:0] y_mag;
    logic [MAG_W-1:0] z_mag;
    logic [2*MAG_W-1:0] x_prod;
    logic [2*MAG_W-1:0] y_prod;
    logic [2*MAG_W-1:0] z_prod;

    logic           sum_valid_reg;
    logic           sum_rdy;
    srch_t          sum_reg;
    srch_t          sum_next;
    logic [T_W-1:0] t_sum;

    logic  lk_valid_reg  [SEARCH_STEPS];
    logic  lk_rdy        [SEARCH_STEPS];
    lk_t   lk_reg        [SEARCH_STEPS];
    lk_t   lk_next       [SEARCH_STEPS];
    logic  mul_valid_reg [SEARCH_STEPS];
    logic  mul_rdy       [SEARCH_STEPS];
    mul_t  mul_reg       [SEARCH_STEPS];
    mul_t  mul_next      [SEARCH_STEPS];
    logic  cmp_valid_reg [SEARCH_STEPS];
    logic  cmp_rdy       [SEARCH_STEPS];
    srch_t cmp_reg       [SEARCH_STEPS];
    srch_t cmp_next      [SEARCH_STEPS];

    logic             out_valid_reg;
    logic             out_rdy;
    angles_t          out_reg;
    angles_t          out_next;
    srch_t            last;
    logic [CNT_W-1:0] roll_cnt;
    logic [CNT_W-1:0] pitch_cnt;
    logic [ANG_W-1:0] roll_mag;
    logic [ANG_W-1:0] pitch_mag;

    // ready chain, back to front
    assign out_rdy      = !out_valid_reg || !angles_stall;
    assign sum_rdy      = !sum_valid_reg || lk_rdy[0];
    assign sq_rdy       = !sq_valid_reg || sum_rdy;
    assign sample_stall = !sq_rdy;

    // squares
    always_comb
    begin
        x_mag = abs16(sample.accel_x);
        y_mag = abs16(sample.accel_y);
        z_mag = abs16(sample.accel_z);
        x_prod = (2*MAG_W)'(x_mag) * (2*MAG_W)'(x_mag);
        y_prod = (2*MAG_W)'(y_mag) * (2*MAG_W)'(y_mag);
        z_prod = (2*MAG_W)'(z_mag) * (2*MAG_W)'(z_mag);
        sq_next.x2    = x_prod[SQ_W-1:0];
        sq_next.y2    = y_prod[SQ_W-1:0];
        sq_next.z2    = z_prod[SQ_W-1:0];
        sq_next.x_neg = sample.accel_x[IN_W-1];
        sq_next.y_neg = sample.accel_y[IN_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (sq_rdy)
        begin
            sq_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_rdy)
        begin
            sq_reg <= sq_next;
        end
    end

    // common sum of squares, lanes set up
    always_comb
    begin
        t_sum = T_W'(sq_reg.x2) + T_W'(sq_reg.y2) + T_W'(sq_reg.z2);
        sum_next.t          = t_sum;
        sum_next.zero       = (t_sum == '0);
        sum_next.roll.n2    = sq_reg.y2;
        sum_next.roll.cnt   = '0;
        sum_next.roll.neg   = sq_reg.y_neg;
        sum_next.pitch.n2   = sq_reg.x2;
        sum_next.pitch.cnt  = '0;
        sum_next.pitch.neg  = ~sq_reg.x_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_rdy)
        begin
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_rdy)
        begin
            sum_reg <= sum_next;
        end
    end

    // binary search over the degree thresholds, one result bit per step
    for (genvar j = 0; j < SEARCH_STEPS; j++)
    begin : g_step
        localparam logic [CNT_W-1:0] STEP_BIT = CNT_W'(1) << (SEARCH_STEPS - 1 - j);

        srch_t src;
        logic  src_valid;
        logic  next_rdy;

        if (j == 0)
        begin : g_first
            assign src       = sum_reg;
            assign src_valid = sum_valid_reg;
        end
        else
        begin : g_inner
            assign src       = cmp_reg[j-1];
            assign src_valid = cmp_valid_reg[j-1];
        end

        if (j == SEARCH_STEPS - 1)
        begin : g_last
            assign next_rdy = out_rdy;
        end
        else
        begin : g_mid
            assign next_rdy = lk_rdy[j+1];
        end

        assign cmp_rdy[j] = !cmp_valid_reg[j] || next_rdy;
        assign mul_rdy[j] = !mul_valid_reg[j] || cmp_rdy[j];
        assign lk_rdy[j]  = !lk_valid_reg[j] || mul_rdy[j];

        // threshold lookup
        always_comb
        begin
            lk_next[j].s         = src;
            lk_next[j].roll_tab  = SIN2_TAB[src.roll.cnt | STEP_BIT];
            lk_next[j].pitch_tab = SIN2_TAB[src.pitch.cnt | STEP_BIT];
        end

        // partial products of threshold and sum
        always_comb
        begin
            mul_next[j].s = lk_reg[j].s;
            mul_next[j].roll_prod.hi =
                PROD_W'(lk_reg[j].roll_tab[TAB_W-1:HALF_W]) * PROD_W'(lk_reg[j].s.t);
            mul_next[j].roll_prod.lo =
                PROD_W'(lk_reg[j].roll_tab[HALF_W-1:0]) * PROD_W'(lk_reg[j].s.t);
            mul_next[j].pitch_prod.hi =
                PROD_W'(lk_reg[j].pitch_tab[TAB_W-1:HALF_W]) * PROD_W'(lk_reg[j].s.t);
            mul_next[j].pitch_prod.lo =
                PROD_W'(lk_reg[j].pitch_tab[HALF_W-1:0]) * PROD_W'(lk_reg[j].s.t);
        end

        // compare and take the bit
        always_comb
        begin
            cmp_next[j] = mul_reg[j].s;
            if (thr_pass(mul_reg[j].s.roll.n2, mul_reg[j].roll_prod))
            begin
                cmp_next[j].roll.cnt = mul_reg[j].s.roll.cnt | STEP_BIT;
            end
            if (thr_pass(mul_reg[j].s.pitch.n2, mul_reg[j].pitch_prod))
            begin
                cmp_next[j].pitch.cnt = mul_reg[j].s.pitch.cnt | STEP_BIT;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lk_valid_reg[j]  <= 1'b0;
                mul_valid_reg[j] <= 1'b0;
                cmp_valid_reg[j] <= 1'b0;
            end
            else
            begin
                if (lk_rdy[j])
                begin
                    lk_valid_reg[j] <= src_valid;
                end
                if (mul_rdy[j])
                begin
                    mul_valid_reg[j] <= lk_valid_reg[j];
                end
                if (cmp_rdy[j])
                begin
                    cmp_valid_reg[j] <= mul_valid_reg[j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (lk_rdy[j])
            begin
                lk_reg[j] <= lk_next[j];
            end
            if (mul_rdy[j])
            begin
                mul_reg[j] <= mul_next[j];
            end
            if (cmp_rdy[j])
            begin
                cmp_reg[j] <= cmp_next[j];
            end
        end
    end

    // sign and all-zero sample
    assign last = cmp_reg[SEARCH_STEPS-1];

    always_comb
    begin
        roll_cnt  = last.zero ? '0 : last.roll.cnt;
        pitch_cnt = last.zero ? '0 : last.pitch.cnt;
        roll_mag  = ANG_W'(roll_cnt);
        pitch_mag = ANG_W'(pitch_cnt);
        out_next.roll_degrees  = last.roll.neg ? -roll_mag : roll_mag;
        out_next.pitch_degrees = last.pitch.neg ? -pitch_mag : pitch_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_valid_reg <= cmp_valid_reg[SEARCH_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            out_reg <= out_next;
        end
    end

    assign angles_valid = out_valid_reg;
    assign angles       = out_reg;

    `ATA_ASSERT_IMP(a_roll_range, clk, rst_n, angles_valid, (angles.roll_degrees >= -8'sd90) && (angles.roll_degrees <= 8'sd90))
    `ATA_ASSERT_IMP(a_roll90_pitch0, clk, rst_n, angles_valid && (angles.roll_degrees == 8'sd90 || angles.roll_degrees == -8'sd90), angles.pitch_degrees == 8'sd0)
    `ATA_ASSERT_NXT(a_accept_fills, clk, rst_n, sample_valid && !sample_stall, sq_valid_reg)
    `ATA_ASSERT_NXT(a_last_moves, clk, rst_n, cmp_valid_reg[SEARCH_STEPS-1] && out_rdy, out_valid_reg)

endmodule

// ===== sim/tb_accel_tilt_angles_core.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_accel_tilt_angles_core
// drives accelerometer samples into the tilt angle core and checks the roll and
// pitch angles against a predictor that counts whole-degree sin squared
// thresholds with 120 fraction bits, with random idling on both sides
//------------------------------------------------------------------------------
module tb_accel_tilt_angles_core;

    import ata_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int FRAC_B      = 120;
    localparam int DRAIN_WAIT  = 40;
    localparam int NUM_RANDOM  = 1600;

    typedef logic [255:0] wide_t;

    class angle_checker;
        wide_t   sin2_deg [90];
        wide_t   one_fix;
        angles_t pending_angles [$];
        int      mismatches;

        function new();
            wide_t pi_fix;
            wide_t rad;
            wide_t p;
            wide_t s1;
            wide_t c1;
            wide_t s;
            wide_t c;
            wide_t ns;
            wide_t nc;
            mismatches = 0;
            one_fix = wide_t'(1) << FRAC_B;
            pi_fix = wide_t'(16) * atan_recip(5) - wide_t'(4) * atan_recip(239);
            rad = pi_fix / wide_t'(180);
            p = one_fix;
            s1 = '0;
            c1 = one_fix;
            for (int n = 1; n < 80; n++)
            begin
                p = mul_fix(p, rad) / wide_t'(n);
                if (p == '0)
                    break;
                case (n % 4)
                    1: s1 = s1 + p;
                    2: c1 = c1 - p;
                    3: s1 = s1 - p;
                    default: c1 = c1 + p;
                endcase
            end
            s = s1;
            c = c1;
            sin2_deg[0] = '0;
            sin2_deg[1] = mul_fix(s, s);
            for (int k = 2; k < 90; k++)
            begin
                nc = mul_fix(c, c1) - mul_fix(s, s1);
                ns = mul_fix(s, c1) + mul_fix(c, s1);
                c = nc;
                s = ns;
                sin2_deg[k] = mul_fix(s, s);
            end
        endfunction

        function wide_t mul_fix(input wide_t a, input wide_t b);
            return (a * b) >> FRAC_B;
        endfunction

        // atan(1/q) by its series
        function wide_t atan_recip(input int unsigned q);
            wide_t term;
            wide_t sum;
            wide_t q2;
            wide_t t;
            term = one_fix / wide_t'(q);
            sum = term;
            q2 = wide_t'(q) * wide_t'(q);
            for (int j = 1; j < 200; j++)
            begin
                term = term / q2;
                if (term == '0)
                    break;
                t = term / wide_t'(2 * j + 1);
                if (j % 2 == 1)
                    sum = sum - t;
                else
                    sum = sum + t;
            end
            return sum;
        endfunction

        // whole degrees of atan2(n, sqrt(m2)), truncated toward zero
        function int trunc_tilt_deg(input int n, input longint unsigned m2);
            longint unsigned n2;
            longint unsigned t;
            wide_t           lhs;
            bit              pass;
            int              count;
            n2 = longint'(n) * longint'(n);
            t = n2 + m2;
            count = 0;
            if (t == 0)
                return 0;
            if (m2 == 0)
                count = 90;
            else
            begin
                lhs = wide_t'(n2) << FRAC_B;
                for (int k = 1; k < 90; k++)
                begin
                    if (k == 30)
                        pass = 4 * n2 >= t;
                    else if (k == 45)
                        pass = 2 * n2 >= t;
                    else if (k == 60)
                        pass = 4 * n2 >= 3 * t;
                    else
                        pass = lhs >= sin2_deg[k] * wide_t'(t);
                    if (!pass)
                        break;
                    count++;
                end
            end
            return (n < 0) ? -count : count;
        endfunction

        function void note_sample(input sample_t smp);
            int              ax;
            int              ay;
            int              az;
            longint unsigned x2;
            longint unsigned y2;
            longint unsigned z2;
            angles_t         e;
            ax = smp.accel_x;
            ay = smp.accel_y;
            az = smp.accel_z;
            x2 = longint'(ax) * longint'(ax);
            y2 = longint'(ay) * longint'(ay);
            z2 = longint'(az) * longint'(az);
            e.roll_degrees = ANG_W'(trunc_tilt_deg(ay, x2 + z2));
            e.pitch_degrees = ANG_W'(-trunc_tilt_deg(ax, y2 + z2));
            pending_angles.push_back(e);
        endfunction

        function void check_angles(input angles_t got);
            angles_t e;
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected angles transfer, got roll %0d pitch %0d",
                         $time, got.roll_degrees, got.pitch_degrees);
                mismatches++;
                return;
            end
            e = pending_angles.pop_front();
            if (got.roll_degrees !== e.roll_degrees)
            begin
                $display("%0t: roll mismatch, expected %0d, got %0d",
                         $time, e.roll_degrees, got.roll_degrees);
                mismatches++;
            end
            if (got.pitch_degrees !== e.pitch_degrees)
            begin
                $display("%0t: pitch mismatch, expected %0d, got %0d",
                         $time, e.pitch_degrees, got.pitch_degrees);
                mismatches++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    angles_valid;
    logic    angles_stall = 1'b0;
    angles_t angles;

    angle_checker sb;
    bit           send_idle = 1'b1;
    bit           recv_idle = 1'b1;

    accel_tilt_angles_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .angles_valid (angles_valid),
        .angles_stall (angles_stall),
        .angles       (angles)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic sample_t pack_sample(input int x, input int y, input int z);
        sample_t s;
        s.accel_x = IN_W'(x);
        s.accel_y = IN_W'(y);
        s.accel_z = IN_W'(z);
        return s;
    endfunction

    function automatic int with_sign(input int v);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    function automatic sample_t random_sample();
        int vals [3];
        int a;
        int m;
        int rot;
        rot = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                vals[0] = $signed(16'($urandom));
                vals[1] = $signed(16'($urandom));
                vals[2] = $signed(16'($urandom));
            end
            4, 5:
            begin
                vals[0] = int'($urandom_range(0, 16)) - 8;
                vals[1] = int'($urandom_range(0, 16)) - 8;
                vals[2] = int'($urandom_range(0, 16)) - 8;
            end
            6:
            begin
                vals[0] = with_sign($urandom_range(20000, 32767));
                vals[1] = int'($urandom_range(0, 128)) - 64;
                vals[2] = int'($urandom_range(0, 128)) - 64;
            end
            7, 8:
            begin
                // exact forty-five degrees and pythagorean triples
                if ($urandom_range(0, 1) == 1)
                begin
                    a = $urandom_range(1, 32767);
                    vals[0] = with_sign(a);
                    vals[1] = with_sign(a);
                    vals[2] = 0;
                end
                else
                begin
                    a = $urandom_range(1, 6553);
                    vals[0] = with_sign(3 * a);
                    vals[1] = with_sign(4 * a);
                    vals[2] = with_sign(5 * a);
                end
            end
            default:
            begin
                // close to thirty and sixty degrees
                m = $urandom_range(1, 18000);
                vals[0] = with_sign($rtoi(m * 1.7320508075688772) +
                                    int'($urandom_range(0, 2)) - 1);
                vals[1] = with_sign(m);
                vals[2] = ($urandom_range(0, 1) == 1) ? 0 : int'($urandom_range(0, 4)) - 2;
            end
        endcase
        return pack_sample(vals[rot], vals[(rot + 1) % 3], vals[(rot + 2) % 3]);
    endfunction

    // entered just after a falling edge, leaves just after a falling edge
    task automatic send_sample(input sample_t smp);
        int gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= smp;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(smp);
        @(negedge clk);
    endtask

    initial
    begin
        int stall_cycles;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall_cycles = recv_idle ? $urandom_range(0, 19) : 0;
            if (stall_cycles > 0)
            begin
                angles_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            angles_stall <= 1'b0;
            do
                @(posedge clk);
            while (!angles_valid);
            sb.check_angles(angles);
            @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("accel_tilt_angles_core test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // axes, extremes, the zero vector, forty-five degrees, near thirty and sixty
        send_sample(pack_sample(0, 0, 0));
        send_sample(pack_sample(32767, 0, 0));
        send_sample(pack_sample(-32768, 0, 0));
        send_sample(pack_sample(0, 32767, 0));
        send_sample(pack_sample(0, -32768, 0));
        send_sample(pack_sample(0, 0, 32767));
        send_sample(pack_sample(0, 0, -32768));
        send_sample(pack_sample(32767, 32767, 32767));
        send_sample(pack_sample(-32768, -32768, -32768));
        send_sample(pack_sample(-32768, 32767, -32768));
        send_sample(pack_sample(32767, -32768, 0));
        send_sample(pack_sample(1, 1, 0));
        send_sample(pack_sample(-1, -1, 0));
        send_sample(pack_sample(100, 0, -100));
        send_sample(pack_sample(0, -5, 5));
        send_sample(pack_sample(-18000, 24000, 0));
        send_sample(pack_sample(12000, 9000, -20000));
        send_sample(pack_sample(0, 1000, 1732));
        send_sample(pack_sample(0, 1000, 1733));
        send_sample(pack_sample(1732, 1000, 0));
        send_sample(pack_sample(1733, 1000, 0));
        send_sample(pack_sample(0, 5, 0));
        send_sample(pack_sample(0, 0, -1));
        send_sample(pack_sample(1, -1, 1));
        send_sample(pack_sample(-1, 0, 0));

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 128 == 0)
            begin
                send_idle = $urandom_range(0, 3) != 0;
                recv_idle = $urandom_range(0, 3) != 0;
            end
            send_sample(random_sample());
        end
        sample_valid <= 1'b0;

        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0)
            $display("accel_tilt_angles_core test passed");
        else
            $display("accel_tilt_angles_core test failed");
        $finish;
    end

endmodule
